FILE: design/i2cs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cs_pkg;

  // Counter width default
  localparam int unsigned CountBitsDefault = 8;

  // Field widths
  localparam int unsigned AddrBits = 7;
  localparam int unsigned LenBits  = 8;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned CmdBits  = 3;

  // Configuration port
  localparam int unsigned CfgIndexBits = 2;
  localparam int unsigned CfgDataBits  = 8;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_SLAVE_ADDRESS = 2'd0,
    CFG_WRITE_LENGTH  = 2'd1,
    CFG_READ_LENGTH   = 2'd2
  } cfg_index_t;

  // Stream payload widths
  localparam int unsigned InDataBits  = 24;  // nacked, rx byte, tx byte, pad
  localparam int unsigned OutDataBits = 32;  // seven result fields, pad

  // Bus engine commands
  typedef enum logic [CmdBits-1:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_RSTART    = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5,
    CMD_STOP      = 3'd6
  } cmd_t;

  // Event kinds carried in the input tuser
  localparam logic FUNC_BEGIN    = 1'b0;
  localparam logic FUNC_COMPLETE = 1'b1;

  // Transaction phase, one-hot
  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_START  = 8'b0000_0010,
    PH_WADDR  = 8'b0000_0100,
    PH_WDATA  = 8'b0000_1000,
    PH_RSTART = 8'b0001_0000,
    PH_RADDR  = 8'b0010_0000,
    PH_READ   = 8'b0100_0000,
    PH_STOP   = 8'b1000_0000
  } phase_t;

  // Configuration register values
  typedef struct packed {
    logic [AddrBits-1:0] slave_address;
    logic [LenBits-1:0]  write_length;
    logic [LenBits-1:0]  read_length;
  } cfg_t;

  // One result beat
  typedef struct packed {
    cmd_t                bus_command;
    logic [ByteBits-1:0] command_byte;
    logic [ByteBits-1:0] write_index;
    logic                read_valid;
    logic [ByteBits-1:0] read_data;
    logic                finished;
    logic                result_status;
  } result_t;

endpackage

`default_nettype wire

FILE: design/i2cs_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cs_cfg_regs
  import i2cs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CfgIndexBits-1:0] cfg_addr,
  input  wire logic [CfgDataBits-1:0]  cfg_wdata,
  output cfg_t                         cfg
);

  // Register file; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SLAVE_ADDRESS: cfg.slave_address <= cfg_wdata[AddrBits-1:0];
        CFG_WRITE_LENGTH:  cfg.write_length  <= cfg_wdata[LenBits-1:0];
        CFG_READ_LENGTH:   cfg.read_length   <= cfg_wdata[LenBits-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/i2cs_core.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cs_core
  import i2cs_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                fire,
  input  wire logic                func,
  input  wire logic                slave_nacked,
  input  wire logic [ByteBits-1:0] received_byte,
  input  wire logic [ByteBits-1:0] next_write_byte,
  output result_t                  result
);

  localparam int unsigned ExtBits = (COUNT_BITS > LenBits) ? COUNT_BITS : LenBits;

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] written_count, written_count_next;
  logic [COUNT_BITS-1:0] read_count, read_count_next;
  logic                  error_seen, error_seen_next;

  logic [ExtBits-1:0]    wlen_ext, rlen_ext, wcount_ext;
  logic [COUNT_BITS-1:0] wlen, rlen, wc_inc;
  logic [ByteBits-1:0]   addr_w, addr_r;
  cmd_t                  cmd;
  logic [ByteBits-1:0]   cbyte;
  logic                  rvalid, fin;

  // Lengths compared modulo 2^COUNT_BITS
  assign wlen_ext = ExtBits'(cfg.write_length);
  assign rlen_ext = ExtBits'(cfg.read_length);
  assign wlen     = wlen_ext[COUNT_BITS-1:0];
  assign rlen     = rlen_ext[COUNT_BITS-1:0];
  assign addr_w   = {cfg.slave_address, 1'b0};
  assign addr_r   = {cfg.slave_address, 1'b1};

  // Next read command, or STOP once all bytes are in
  function automatic cmd_t read_cmd(input logic [COUNT_BITS-1:0] cnt,
                                    input logic [COUNT_BITS-1:0] len);
    cmd_t c;
    if (cnt < len) begin
      c = ((cnt + 1'b1) < len) ? CMD_READ_ACK : CMD_READ_NACK;
    end else begin
      c = CMD_STOP;
    end
    return c;
  endfunction

  // Event decode: one command per event
  always_comb begin
    phase_next         = phase;
    written_count_next = written_count;
    read_count_next    = read_count;
    error_seen_next    = error_seen;
    cmd                = CMD_NONE;
    cbyte              = '0;
    rvalid             = 1'b0;
    fin                = 1'b0;
    wc_inc             = written_count + 1'b1;

    if (func == FUNC_BEGIN) begin
      if (phase == PH_IDLE) begin
        written_count_next = '0;
        read_count_next    = '0;
        error_seen_next    = 1'b0;
        cmd                = CMD_START;
        phase_next         = PH_START;
      end
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_START: begin
          if (wlen != '0) begin
            cmd        = CMD_WRITE;
            cbyte      = addr_w;
            phase_next = PH_WADDR;
          end else if (rlen != '0) begin
            cmd        = CMD_WRITE;
            cbyte      = addr_r;
            phase_next = PH_RADDR;
          end else begin
            cmd        = CMD_STOP;
            phase_next = PH_STOP;
          end
        end
        PH_WADDR, PH_WDATA: begin
          if (slave_nacked) begin
            error_seen_next = 1'b1;
            cmd             = CMD_STOP;
            phase_next      = PH_STOP;
          end else begin
            if (phase == PH_WDATA) written_count_next = wc_inc;
            if (written_count_next < wlen) begin
              cmd        = CMD_WRITE;
              cbyte      = next_write_byte;
              phase_next = PH_WDATA;
            end else if (rlen != '0) begin
              cmd        = CMD_RSTART;
              phase_next = PH_RSTART;
            end else begin
              cmd        = CMD_STOP;
              phase_next = PH_STOP;
            end
          end
        end
        PH_RSTART: begin
          cmd        = CMD_WRITE;
          cbyte      = addr_r;
          phase_next = PH_RADDR;
        end
        PH_RADDR: begin
          if (slave_nacked) begin
            error_seen_next = 1'b1;
            cmd             = CMD_STOP;
            phase_next      = PH_STOP;
          end else begin
            cmd        = read_cmd(read_count, rlen);
            phase_next = (cmd == CMD_STOP) ? PH_STOP : PH_READ;
          end
        end
        PH_READ: begin
          rvalid          = 1'b1;
          read_count_next = read_count + 1'b1;
          cmd             = read_cmd(read_count_next, rlen);
          phase_next      = (cmd == CMD_STOP) ? PH_STOP : PH_READ;
        end
        PH_STOP: begin
          fin        = 1'b1;
          phase_next = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  assign wcount_ext = ExtBits'(written_count_next);

  // Result fields for this beat
  always_comb begin
    result.bus_command   = cmd;
    result.command_byte  = cbyte;
    result.write_index   = wcount_ext[ByteBits-1:0];
    result.read_valid    = rvalid;
    result.read_data     = rvalid ? received_byte : '0;
    result.finished      = fin;
    result.result_status = error_seen_next;
  end

  // Transaction state, advanced on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      written_count <= '0;
      read_count    <= '0;
      error_seen    <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      written_count <= written_count_next;
      read_count    <= read_count_next;
      error_seen    <= error_seen_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/i2cs_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cs_out_reg
  import i2cs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire result_t                result,
  output logic                        room,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OutDataBits-1:0]      m_axis_tdata
);

  localparam int unsigned ResBits = $bits(result_t);

  result_t held;

  // Free when empty or the held beat leaves this cycle
  assign room = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (room) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) held <= result;
  end

  // Pack fields, first field lowest
  assign m_axis_tdata = {
    {(OutDataBits - ResBits){1'b0}},
    held.result_status,
    held.finished,
    held.read_data,
    held.read_valid,
    held.write_index,
    held.command_byte,
    held.bus_command
  };

endmodule

`default_nettype wire

FILE: design/i2c_master_transaction_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata (lsb up)                                    tuser
// s_axis    in   slave_nacked, received_byte, next_write_byte, pad func
// m_axis    out  bus_command, command_byte, write_index,           -
//                read_valid, read_data, finished, result_status, pad
// cfg       in   cfg_we, cfg_addr (0 addr, 1 wr len, 2 rd len), cfg_wdata
//
// One event per cycle while m_axis is not stalled: each event is decoded
// combinationally by the phase state machine into the output register.
// The input takes a new beat whenever the output register is empty or
// draining, so a stalled m_axis holds one result and back-pressures s_axis.
// Synchronous reset returns to idle with cleared counters, config and tvalid.

module i2c_master_transaction_sequencer
  import i2cs_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [InDataBits-1:0]   s_axis_tdata,   // slave_nacked, received_byte, next_write_byte
  input  wire logic                    s_axis_tuser,   // func
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OutDataBits-1:0]       m_axis_tdata,   // bus_command .. result_status
  input  wire logic                    cfg_we,
  input  wire logic [CfgIndexBits-1:0] cfg_addr,
  input  wire logic [CfgDataBits-1:0]  cfg_wdata
);

  cfg_t    cfg;
  result_t result;
  logic    room;
  logic    fire;

  assign s_axis_tready = room;
  assign fire          = s_axis_tvalid && room;

  i2cs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  i2cs_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .fire            (fire),
    .func            (s_axis_tuser),
    .slave_nacked    (s_axis_tdata[0]),
    .received_byte   (s_axis_tdata[8:1]),
    .next_write_byte (s_axis_tdata[16:9]),
    .result          (result)
  );

  i2cs_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (fire),
    .result        (result),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
